@@ sv/xlsf_pkg.sv @@
package xlsf_pkg;

  // Operation codes carried on the action field.
  localparam logic [3:0] ACT_TEST  = 4'd0;
  localparam logic [3:0] ACT_AND   = 4'd1;
  localparam logic [3:0] ACT_XOR   = 4'd2;
  localparam logic [3:0] ACT_OR    = 4'd3;
  localparam logic [3:0] ACT_SAR   = 4'd4;
  localparam logic [3:0] ACT_SHL   = 4'd5;
  localparam logic [3:0] ACT_SHR   = 4'd6;
  localparam logic [3:0] ACT_SETCC = 4'd7;
  localparam logic [3:0] ACT_NOT   = 4'd8;
  localparam logic [3:0] ACT_ROL   = 4'd9;
  // First and last of the codes that name no operation.
  localparam logic [3:0] ACT_SPARE_FIRST = 4'd10;
  localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;

  // Operand width codes; the unused code behaves as doubleword.
  localparam logic [1:0] WIDTH_BYTE  = 2'd0;
  localparam logic [1:0] WIDTH_WORD  = 2'd1;
  localparam logic [1:0] WIDTH_DWORD = 2'd2;
  localparam logic [1:0] WIDTH_SPARE = 2'd3;

  // Condition groups (condition code without its inversion bit).
  localparam logic [2:0] COND_O  = 3'd0;
  localparam logic [2:0] COND_B  = 3'd1;
  localparam logic [2:0] COND_Z  = 3'd2;
  localparam logic [2:0] COND_BE = 3'd3;
  localparam logic [2:0] COND_S  = 3'd4;
  localparam logic [2:0] COND_P  = 3'd5;
  localparam logic [2:0] COND_L  = 3'd6;
  localparam logic [2:0] COND_LE = 3'd7;

  // Full condition codes.
  localparam logic [3:0] CC_O   = 4'd0;
  localparam logic [3:0] CC_NB  = 4'd3;
  localparam logic [3:0] CC_NLE = 4'd15;

  // Parity condition codes, which the unit does not evaluate.
  localparam logic [3:0] CC_P  = 4'd10;
  localparam logic [3:0] CC_NP = 4'd11;

  typedef struct packed {
    logic carry;
    logic overflow;
    logic zero;
    logic sign;
  } flags_t;

endpackage

@@ sv/x86_logic_shift_flag_unit.sv @@
// Each accepted transaction passes through the input register and then the output
// register, where its result is presented; out_ready low can hold it in either.
// Throughput: one transaction per cycle while out_ready holds no result back; the
// held flags feed forward from one operation to the next through the flag register.
// Reset (rst, synchronous, active high) empties both pipeline registers and
// clears CF, OF, ZF and SF to zero.
module x86_logic_shift_flag_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] dest_value,
  input  logic [31:0] src_value,
  input  logic [1:0]  width_code,
  input  logic        sign_extend_src,
  input  logic [3:0]  cond_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_value,
  output logic        write_back,
  output logic        carry_flag,
  output logic        overflow_flag,
  output logic        zero_flag,
  output logic        sign_flag,
  output logic        unsupported
);
  import xlsf_pkg::*;

  // The input register captures each transaction as it is accepted. The
  // execution logic works on the registered operands together with the
  // architectural flags, and its result lands in the output register.
  logic        stage_valid;
  logic [3:0]  stage_action;
  logic [31:0] stage_dest;
  logic [31:0] stage_src;
  logic [1:0]  stage_width;
  logic        stage_sext;
  logic [3:0]  stage_cc;

  // Architectural flags. They are committed at the moment an operation moves
  // into the output register, so the next operation sees them from the input register.
  flags_t flags;
  flags_t flags_next;

  logic [31:0] exec_result;
  logic        exec_write_back;
  logic        exec_unsupported;
  logic        advance;

  // The output register may take a new result whenever it is empty or its
  // current result is being taken this cycle.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  xlsf_exec u_exec (
    .action          (stage_action),
    .dest_value      (stage_dest),
    .src_value       (stage_src),
    .width_code      (stage_width),
    .sign_extend_src (stage_sext),
    .cond_code       (stage_cc),
    .flags_in        (flags),
    .result_value    (exec_result),
    .write_back      (exec_write_back),
    .unsupported     (exec_unsupported),
    .flags_out       (flags_next)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      stage_action <= action;
      stage_dest   <= dest_value;
      stage_src    <= src_value;
      stage_width  <= width_code;
      stage_sext   <= sign_extend_src;
      stage_cc     <= cond_code;
    end
  end

  // Flag register and output register. The flags reported with a result are
  // the flags as they stand after that operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '0;
    end else begin
      if (advance) begin
        out_valid <= stage_valid;
      end
      if (advance && stage_valid) begin
        flags <= flags_next;
      end
    end
    if (advance && stage_valid) begin
      result_value  <= exec_result;
      write_back    <= exec_write_back;
      unsupported   <= exec_unsupported;
      carry_flag    <= flags_next.carry;
      overflow_flag <= flags_next.overflow;
      zero_flag     <= flags_next.zero;
      sign_flag     <= flags_next.sign;
    end
  end

endmodule

@@ sv/xlsf_exec.sv @@
module xlsf_exec (
  input  logic [3:0]     action,
  input  logic [31:0]    dest_value,
  input  logic [31:0]    src_value,
  input  logic [1:0]     width_code,
  input  logic           sign_extend_src,
  input  logic [3:0]     cond_code,
  input  xlsf_pkg::flags_t flags_in,
  output logic [31:0]    result_value,
  output logic           write_back,
  output logic           unsupported,
  output xlsf_pkg::flags_t flags_out
);
  import xlsf_pkg::*;

  logic [31:0] mask;
  logic [31:0] dst;
  logic [31:0] src_ext;
  logic [31:0] logic_res;
  logic [4:0]  cnt;
  logic        dst_msb;
  logic signed [31:0] sar_in;
  logic [31:0] sar_res;
  logic [15:0] rot8;
  logic [31:0] rot16;
  logic [63:0] rot32;
  logic [31:0] rol_res;
  logic        cond_hit;
  logic        res_msb;

  always_comb begin
    case (width_code)
      WIDTH_BYTE: mask = 32'h0000_00FF;
      WIDTH_WORD: mask = 32'h0000_FFFF;
      default:    mask = 32'hFFFF_FFFF;
    endcase
  end

  assign dst = dest_value & mask;
  assign cnt = src_value[4:0];

  always_comb begin
    case (width_code)
      WIDTH_BYTE: dst_msb = dest_value[7];
      WIDTH_WORD: dst_msb = dest_value[15];
      default:    dst_msb = dest_value[31];
    endcase
  end

  // Source for the logic group, optionally sign-extended from its low byte.
  assign src_ext = (sign_extend_src ? {{24{src_value[7]}}, src_value[7:0]} : src_value) & mask;

  // Arithmetic shift: the operand is widened by its own sign so that one 32-bit
  // arithmetic shift serves every width.
  assign sar_in  = signed'(dst | (dst_msb ? ~mask : 32'h0));
  assign sar_res = 32'(sar_in >>> cnt) & mask;

  // Rotates: the upper half of the doubled operand shifted left.
  assign rot8  = {dst[7:0], dst[7:0]} << cnt[2:0];
  assign rot16 = {dst[15:0], dst[15:0]} << cnt[3:0];
  assign rot32 = {dst, dst} << cnt;

  always_comb begin
    case (width_code)
      WIDTH_BYTE: rol_res = {24'h0, rot8[15:8]};
      WIDTH_WORD: rol_res = {16'h0, rot16[31:16]};
      default:    rol_res = rot32[63:32];
    endcase
  end

  always_comb begin
    case (cond_code[3:1])
      COND_O:  cond_hit = flags_in.overflow;
      COND_B:  cond_hit = flags_in.carry;
      COND_Z:  cond_hit = flags_in.zero;
      COND_BE: cond_hit = flags_in.carry | flags_in.zero;
      COND_S:  cond_hit = flags_in.sign;
      COND_L:  cond_hit = flags_in.sign ^ flags_in.overflow;
      COND_LE: cond_hit = flags_in.zero | (flags_in.sign ^ flags_in.overflow);
      default: cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    case (action)
      ACT_XOR: logic_res = dst ^ src_ext;
      ACT_OR:  logic_res = dst | src_ext;
      default: logic_res = dst & src_ext;
    endcase
  end

  always_comb begin
    result_value = 32'h0;
    write_back   = 1'b0;
    unsupported  = 1'b0;
    case (action)
      ACT_TEST, ACT_AND, ACT_XOR, ACT_OR: begin
        result_value = logic_res;
        write_back   = (action != ACT_TEST);
      end
      ACT_SAR: begin
        result_value = sar_res;
        write_back   = 1'b1;
      end
      ACT_SHL: begin
        result_value = (dst << cnt) & mask;
        write_back   = 1'b1;
      end
      ACT_SHR: begin
        result_value = dst >> cnt;
        write_back   = 1'b1;
      end
      ACT_SETCC: begin
        if (cond_code inside {CC_P, CC_NP}) begin
          unsupported = 1'b1;
        end else begin
          result_value = {31'h0, cond_hit ^ cond_code[0]};
          write_back   = 1'b1;
        end
      end
      ACT_NOT: begin
        result_value = ~dst & mask;
        write_back   = 1'b1;
      end
      ACT_ROL: begin
        result_value = (cnt == 5'd0) ? dst : rol_res;
        write_back   = 1'b1;
      end
      default: begin
        result_value = 32'h0;
      end
    endcase
  end

  always_comb begin
    case (width_code)
      WIDTH_BYTE: res_msb = result_value[7];
      WIDTH_WORD: res_msb = result_value[15];
      default:    res_msb = result_value[31];
    endcase
  end

  always_comb begin
    flags_out = flags_in;
    case (action)
      ACT_TEST, ACT_AND, ACT_XOR, ACT_OR: begin
        flags_out.carry    = 1'b0;
        flags_out.overflow = 1'b0;
        flags_out.zero     = (result_value == 32'h0);
        flags_out.sign     = res_msb;
      end
      ACT_SAR, ACT_SHL, ACT_SHR: begin
        flags_out.zero = (result_value == 32'h0);
        flags_out.sign = res_msb;
      end
      ACT_ROL: begin
        if (cnt != 5'd0) begin
          flags_out.carry    = result_value[0];
          flags_out.overflow = res_msb ^ result_value[0];
        end
      end
      default: begin
        flags_out = flags_in;
      end
    endcase
  end

endmodule

@@ bench/xlsf_flag_checker.sv @@
`timescale 1ns / 100ps

module xlsf_flag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [3:0]  action,
  input  logic [31:0] dest_value,
  input  logic [31:0] src_value,
  input  logic [1:0]  width_code,
  input  logic        sign_extend_src,
  input  logic [3:0]  cond_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_value,
  input  logic        write_back,
  input  logic        carry_flag,
  input  logic        overflow_flag,
  input  logic        zero_flag,
  input  logic        sign_flag,
  input  logic        unsupported,
  output int          mismatch_count,
  output int          results_pending
);
  import xlsf_pkg::*;

  typedef struct packed {
    logic [31:0] value;
    logic        write_back;
    flags_t      flags;
    logic        unsupported;
  } op_result_t;

  // Flags as the unit should hold them after every accepted transaction.
  flags_t     held_flags;
  op_result_t expected_results[$];

  initial begin
    mismatch_count  = 0;
    results_pending = 0;
    held_flags      = '0;
  end

  function automatic logic cond_holds(input logic [3:0] cc);
    logic hit;
    case (cc[3:1])
      COND_O:  hit = held_flags.overflow;
      COND_B:  hit = held_flags.carry;
      COND_Z:  hit = held_flags.zero;
      COND_BE: hit = held_flags.carry | held_flags.zero;
      COND_S:  hit = held_flags.sign;
      COND_L:  hit = held_flags.sign ^ held_flags.overflow;
      COND_LE: hit = held_flags.zero | (held_flags.sign ^ held_flags.overflow);
      default: hit = 1'b0;
    endcase
    return hit ^ cc[0];
  endfunction

  // Computes one operation and advances the held flags.
  function automatic op_result_t execute_op(input logic [3:0] act, input logic [31:0] dst_in,
                                            input logic [31:0] src_in, input logic [1:0] wc,
                                            input logic sx, input logic [3:0] cc);
    op_result_t  r;
    int          bits;
    logic [31:0] mask, dst, src, ext;
    logic [4:0]  cnt;
    int          rot;
    r = '0;
    case (wc)
      WIDTH_BYTE: bits = 8;
      WIDTH_WORD: bits = 16;
      default:    bits = 32;
    endcase
    mask = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
    dst  = dst_in & mask;
    src  = src_in;
    cnt  = src_in[4:0];
    case (act)
      ACT_TEST, ACT_AND, ACT_XOR, ACT_OR: begin
        // The immediate form sign-extends from 8 bits whatever the width.
        if (sx) src = {{24{src_in[7]}}, src_in[7:0]};
        src = src & mask;
        if (act == ACT_XOR) r.value = dst ^ src;
        else if (act == ACT_OR) r.value = dst | src;
        else r.value = dst & src;
        r.write_back = (act != ACT_TEST);
        held_flags.carry    = 1'b0;
        held_flags.overflow = 1'b0;
      end
      ACT_SAR: begin
        ext = dst[bits-1] ? (dst | ~mask) : dst;
        r.value = $unsigned($signed(ext) >>> cnt) & mask;
        r.write_back = 1'b1;
      end
      ACT_SHL: begin
        r.value = (dst << cnt) & mask;
        r.write_back = 1'b1;
      end
      ACT_SHR: begin
        r.value = dst >> cnt;
        r.write_back = 1'b1;
      end
      ACT_SETCC: begin
        if (cc == CC_P || cc == CC_NP) begin
          r.unsupported = 1'b1;
        end else begin
          r.value = {31'd0, cond_holds(cc)};
          r.write_back = 1'b1;
        end
      end
      ACT_NOT: begin
        r.value = ~dst & mask;
        r.write_back = 1'b1;
      end
      ACT_ROL: begin
        r.write_back = 1'b1;
        r.value = dst;
        if (cnt != 5'd0) begin
          // A count that is a multiple of the width still updates CF and OF.
          rot = int'(cnt) & (bits - 1);
          if (rot != 0) r.value = ((dst << rot) | (dst >> (bits - rot))) & mask;
          held_flags.carry    = r.value[0];
          held_flags.overflow = r.value[bits-1] ^ r.value[0];
        end
      end
      default: ;
    endcase
    if (act inside {ACT_TEST, ACT_AND, ACT_XOR, ACT_OR, ACT_SAR, ACT_SHL, ACT_SHR}) begin
      held_flags.zero = (r.value == 32'd0);
      held_flags.sign = r.value[bits-1];
    end
    r.flags = held_flags;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    op_result_t want;
    if (rst) begin
      held_flags = '0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no operation outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_value", want.value, result_value);
          check_field("write_back", 32'(want.write_back), 32'(write_back));
          check_field("carry_flag", 32'(want.flags.carry), 32'(carry_flag));
          check_field("overflow_flag", 32'(want.flags.overflow), 32'(overflow_flag));
          check_field("zero_flag", 32'(want.flags.zero), 32'(zero_flag));
          check_field("sign_flag", 32'(want.flags.sign), 32'(sign_flag));
          check_field("unsupported", 32'(want.unsupported), 32'(unsupported));
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(execute_op(action, dest_value, src_value, width_code,
                                              sign_extend_src, cond_code));
    end
    results_pending <= expected_results.size();
  end

endmodule

@@ bench/tb_x86_logic_shift_flag_unit.sv @@
`timescale 1ns / 100ps

module tb_x86_logic_shift_flag_unit;
  import xlsf_pkg::*;

  // The run is bounded by this many clock cycles.
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_OPS   = 600;
  // Cycles allowed after the last result for anything stray to show up.
  localparam int DRAIN_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  action = ACT_TEST;
  logic [31:0] dest_value = '0;
  logic [31:0] src_value = '0;
  logic [1:0]  width_code = WIDTH_BYTE;
  logic        sign_extend_src = 1'b0;
  logic [3:0]  cond_code = CC_O;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_value;
  logic        write_back;
  logic        carry_flag;
  logic        overflow_flag;
  logic        zero_flag;
  logic        sign_flag;
  logic        unsupported;

  int          fail_count;
  int          results_pending;
  int          cycle_count = 0;
  // When clear, neither side of the unit idles; used for one long stretch of the run.
  logic        idling_on = 1'b1;

  x86_logic_shift_flag_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dest_value(dest_value), .src_value(src_value),
    .width_code(width_code), .sign_extend_src(sign_extend_src), .cond_code(cond_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .write_back(write_back),
    .carry_flag(carry_flag), .overflow_flag(overflow_flag),
    .zero_flag(zero_flag), .sign_flag(sign_flag), .unsupported(unsupported)
  );

  // The checker watches both channels, predicts every result and counts mismatches.
  xlsf_flag_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .dest_value(dest_value), .src_value(src_value),
    .width_code(width_code), .sign_extend_src(sign_extend_src), .cond_code(cond_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .write_back(write_back),
    .carry_flag(carry_flag), .overflow_flag(overflow_flag),
    .zero_flag(zero_flag), .sign_flag(sign_flag), .unsupported(unsupported),
    .mismatch_count(fail_count), .results_pending(results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The result side stalls at random, about 11 percent of the time, except during the
  // stretch where idling is switched off.
  always @(posedge clk)
    out_ready <= !idling_on || ($urandom_range(99) >= 11);

  // A hung handshake or a result that never arrives ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL x86_logic_shift_flag_unit");
      $finish;
    end
  end

  // Presents one operation and holds it until the unit takes the transaction.
  // The valid line is only dropped for an idle cycle, so back-to-back
  // operations keep valid high without a glitch.
  task automatic issue_op(input logic [3:0] act, input logic [31:0] dst, input logic [31:0] src,
                          input logic [1:0] wc, input logic sx, input logic [3:0] cc);
    while (idling_on && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    action          <= act;
    dest_value      <= dst;
    src_value       <= src;
    width_code      <= wc;
    sign_extend_src <= sx;
    cond_code       <= cc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Operand values that drive the flags to their interesting settings: zero,
  // all ones and lone sign bits at each width. Otherwise a fully random word.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(11))
      0:       v = 32'h0000_0000;
      1:       v = 32'hFFFF_FFFF;
      2:       v = 32'h0000_0080;
      3:       v = 32'h0000_8000;
      4:       v = 32'h8000_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  initial begin
    logic [3:0]  act;
    logic [31:0] dst, src;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The logic operations cover the width extremes, the byte
    // immediate sign extension and a result of zero.
    issue_op(ACT_TEST, 32'hFFFF_FFFF, 32'h0000_0080, WIDTH_BYTE, 1'b1, CC_O);
    issue_op(ACT_AND,  32'hFFFF_FFFF, 32'h0000_00FF, WIDTH_DWORD, 1'b1, CC_O);
    issue_op(ACT_XOR,  32'h0000_FFFF, 32'h0000_FFFF, WIDTH_WORD, 1'b0, CC_O);
    issue_op(ACT_OR,   32'h0000_0000, 32'h8000_0000, WIDTH_SPARE, 1'b0, CC_O);
    issue_op(ACT_AND,  32'h1234_5678, 32'hFFFF_FF7F, WIDTH_WORD, 1'b1, CC_O);
    // Shifts: a negative operand shifted right arithmetically past its width,
    // a count of zero, the largest count, and counts with high bits set above
    // the five that are used.
    issue_op(ACT_SAR,  32'h0000_0080, 32'h0000_0009, WIDTH_BYTE, 1'b0, CC_O);
    issue_op(ACT_SAR,  32'h8000_0000, 32'hFFFF_FFFF, WIDTH_DWORD, 1'b0, CC_O);
    issue_op(ACT_SAR,  32'h0000_7FFF, 32'h0000_0000, WIDTH_WORD, 1'b0, CC_O);
    issue_op(ACT_SHL,  32'hFFFF_FFFF, 32'hFFFF_FFE1, WIDTH_BYTE, 1'b0, CC_O);
    issue_op(ACT_SHL,  32'h0000_0001, 32'h0000_001F, WIDTH_DWORD, 1'b0, CC_O);
    issue_op(ACT_SHR,  32'h0000_FFFF, 32'h0000_0010, WIDTH_WORD, 1'b0, CC_O);
    issue_op(ACT_SHR,  32'hFFFF_FFFF, 32'h0000_0020, WIDTH_SPARE, 1'b0, CC_O);
    // Rotates: a zero count keeps every flag, a count equal to the width leaves
    // the value but still sets CF and OF, and ordinary rotates.
    issue_op(ACT_ROL,  32'h0000_0081, 32'h0000_0000, WIDTH_BYTE, 1'b0, CC_O);
    issue_op(ACT_ROL,  32'h0000_8001, 32'h0000_0010, WIDTH_WORD, 1'b0, CC_O);
    issue_op(ACT_ROL,  32'h8000_0000, 32'h0000_0001, WIDTH_DWORD, 1'b0, CC_O);
    issue_op(ACT_ROL,  32'h4000_0001, 32'hFFFF_FFFF, WIDTH_DWORD, 1'b0, CC_O);
    // SETcc over the held flags, both parity conditions, and NOT.
    issue_op(ACT_SETCC, '0, '0, WIDTH_BYTE, 1'b0, CC_O);
    issue_op(ACT_SETCC, '0, '0, WIDTH_BYTE, 1'b0, CC_NB);
    issue_op(ACT_SETCC, '0, '0, WIDTH_BYTE, 1'b0, CC_P);
    issue_op(ACT_SETCC, '0, '0, WIDTH_BYTE, 1'b0, CC_NP);
    issue_op(ACT_SETCC, '0, '0, WIDTH_BYTE, 1'b0, CC_NLE);
    issue_op(ACT_NOT,  32'hFFFF_FF00, 32'h0, WIDTH_BYTE, 1'b0, CC_O);
    issue_op(ACT_NOT,  32'h0000_0000, 32'h0, WIDTH_DWORD, 1'b0, CC_O);
    // Codes beyond the last operation produce an empty result.
    issue_op(ACT_SPARE_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, WIDTH_DWORD, 1'b1, CC_NLE);
    issue_op(ACT_SPARE_LAST,  32'hFFFF_FFFF, 32'hFFFF_FFFF, WIDTH_DWORD, 1'b1, CC_NLE);

    // Random part. Unknown codes are kept rare so that most transactions do
    // real work, and SETcc reads whatever flags the random operations before
    // it left, with a condition code drawn at random.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      idling_on = !(n >= 250 && n < 400);
      if ($urandom_range(99) < 4) act = 4'($urandom_range(ACT_SPARE_LAST, ACT_SPARE_FIRST));
      else act = 4'($urandom_range(ACT_ROL, ACT_TEST));
      dst = pick_operand();
      src = pick_operand();
      issue_op(act, dst, src, 2'($urandom_range(3)), 1'($urandom_range(1)),
               4'($urandom_range(15)));
    end
    in_valid <= 1'b0;
    idling_on = 1'b1;

    // A first wait lets the last transaction reach the checker's count, then the
    // outstanding results drain and a final wait of DRAIN_CYCLES catches anything stray.
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS x86_logic_shift_flag_unit");
    end else begin
      $display("FAIL x86_logic_shift_flag_unit");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/xlsf_pkg.sv
sv/xlsf_exec.sv
sv/x86_logic_shift_flag_unit.sv
bench/xlsf_flag_checker.sv
bench/tb_x86_logic_shift_flag_unit.sv
